// File: src/ctl_pkg.sv
// Package: scanner states, token classes, keyword table and character helpers.
`default_nettype none
package ctl_pkg;
  localparam int MAX_TOKEN_LEN_DEF = 255;
  localparam int KEYWORD_COUNT_DEF = 18;
  localparam int KW_MAX = 32;

  typedef enum logic [4:0] {
    ST_IDLE, ST_WORD, ST_ZERO, ST_ZEROX, ST_HEX, ST_OCT, ST_INT, ST_FRAC0,
    ST_FRAC, ST_EXP0, ST_EXPS, ST_EXPD, ST_SLASH, ST_COMMENT, ST_CSTAR,
    ST_STRING, ST_OP_PLUS, ST_OP_MINUS, ST_OP_STAR, ST_OP_PCT, ST_OP_AMP,
    ST_OP_CARET, ST_OP_BAR, ST_OP_LT, ST_OP_GT, ST_OP_EQ
  } scan_st_t;

  localparam logic [5:0] K_WORD = 6'd0, K_KEYWORD = 6'd1, K_ZERO = 6'd2,
    K_OCT = 6'd3, K_HEX = 6'd4, K_INT = 6'd5, K_FLOAT = 6'd6, K_MAL = 6'd7,
    K_STRING = 6'd8, K_LBRK = 6'd9, K_RBRK = 6'd10, K_LPAR = 6'd11,
    K_RPAR = 6'd12, K_DOT = 6'd13, K_PLUS = 6'd14, K_PLUSEQ = 6'd15,
    K_MINUS = 6'd16, K_MINUSEQ = 6'd17, K_ARROW = 6'd18, K_STAR = 6'd19,
    K_STAREQ = 6'd20, K_SLASH = 6'd21, K_SLASHEQ = 6'd22, K_PCT = 6'd23,
    K_PCTEQ = 6'd24, K_QUEST = 6'd25, K_AMP = 6'd26, K_AMPEQ = 6'd27,
    K_ANDAND = 6'd28, K_TILDE = 6'd29, K_COMMA = 6'd30, K_CARET = 6'd31,
    K_CARETEQ = 6'd32, K_BAR = 6'd33, K_OROR = 6'd34, K_LT = 6'd35,
    K_LE = 6'd36, K_GT = 6'd37, K_GE = 6'd38, K_ASSIGN = 6'd39, K_EQEQ = 6'd40,
    K_USTR1 = 6'd41, K_USTR2 = 6'd42;

  typedef struct packed {
    logic       vld;
    logic [5:0] cls;
    logic [7:0] len;
  } tok_t;

  typedef struct packed {
    tok_t t0;
    tok_t t1;
  } tok_pair_t;

  // Character of keyword r at position p, zero past its end.
  function automatic logic [7:0] kw_char(input int r, input int p);
    logic [8:0][7:0] s;
    case (r)
      0: s = {8'd0, 8'd0, 8'd0, "fo", "ezis"};
      1: s = {56'd0, "fi"};
      2: s = {32'd0, "kaerb"};
      3: s = {40'd0, "esle"};
      4: s = {48'd0, "rof"};
      5: s = {32'd0, "elihw"};
      6: s = {48'd0, "tni"};
      7: s = {40'd0, "rahc"};
      8: s = {40'd0, "otog"};
      9: s = {8'd0, "eunitnoc"};
      10: s = {24'd0, "nruter"};
      11: s = {24'd0, "elbuod"};
      12: s = {32'd0, "taolf"};
      13: s = {40'd0, "gnol"};
      14: s = {32'd0, "tsnoc"};
      15: s = {24'd0, "tcurts"};
      16: s = {8'd0, "dengisnu"};
      17: s = {16'd0, "fedepyt"};
      default: s = '0;
    endcase
    return s[p];
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction
  function automatic logic is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction
  function automatic logic is_oct(input logic [7:0] c);
    return c >= "0" && c <= "7";
  endfunction
  function automatic logic is_hex(input logic [7:0] c);
    return is_digit(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
  endfunction
endpackage
`default_nettype wire

// File: src/c_token_lexer.sv
// Top level: scanner step on the accepted character, two-entry result queue.
// The tokens of an accepted character are registered into the queue and shown on out_ from there.
// Throughput: one character per cycle while out_tready is high and no character gives two
// tokens; such a character holds in_tready low until both of its tokens are popped.
// Reset: synchronous active-low rst_n returns the scanner to idle between tokens
// and empties the queue.
`default_nettype none
module c_token_lexer #(
  parameter int MAX_TOKEN_LEN = ctl_pkg::MAX_TOKEN_LEN_DEF,
  parameter int KEYWORD_COUNT = ctl_pkg::KEYWORD_COUNT_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // ch
  input  wire logic        in_tlast,   // end_of_text
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,  // token_class[5:0], token_length[13:6], 0
  output logic             out_tlast   // last_of_run
);
  ctl_pkg::tok_pair_t toks;
  logic acc;
  // Queue of up to two tokens, with last flags
  ctl_pkg::tok_t q_r [2];
  logic [1:0] qlast_r;
  logic [1:0] cnt_r;

  assign acc = in_tvalid && in_tready;

  ctl_step #(.MAX_TOKEN_LEN(MAX_TOKEN_LEN), .KEYWORD_COUNT(KEYWORD_COUNT)) u_step (
    .clk(clk), .rst_n(rst_n), .step_i(acc), .ch_i(in_tdata), .eot_i(in_tlast),
    .toks_o(toks)
  );

  logic pop;
  logic [1:0] rem;
  assign pop = out_tvalid && out_tready;
  assign rem = cnt_r - {1'b0, pop};
  // Accept when queue after this cycle's pop has room for two
  assign in_tready = (rem == 2'd0);
  assign out_tvalid = (cnt_r != 2'd0);
  assign out_tdata = {2'b0, q_r[0].len, q_r[0].cls};
  assign out_tlast = qlast_r[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      qlast_r <= '0;
    end else begin
      if (pop) begin
        q_r[0] <= q_r[1];
        qlast_r[0] <= qlast_r[1];
      end
      if (acc) begin
        q_r[0] <= toks.t0.vld ? toks.t0 : q_r[0];
        q_r[1] <= toks.t1;
        qlast_r[0] <= !toks.t1.vld;
        qlast_r[1] <= 1'b1;
        cnt_r <= {1'b0, toks.t0.vld} + {1'b0, toks.t1.vld};
      end else begin
        cnt_r <= rem;
      end
    end
  end
endmodule
`default_nettype wire

// File: src/ctl_kw_match.sv
// Keyword matcher: per-keyword match update and keyword test of a word.
`default_nettype none
module ctl_kw_match #(
  parameter int KEYWORD_COUNT = ctl_pkg::KEYWORD_COUNT_DEF,
  parameter int LEN_W = 8
) (
  input  wire logic [KEYWORD_COUNT-1:0] match_i,
  input  wire logic [LEN_W-1:0]         pos_i,
  input  wire logic [7:0]               ch_i,
  output logic      [KEYWORD_COUNT-1:0] match_o,
  output logic                          is_kw_o
);
  always_comb begin
    for (int r = 0; r < KEYWORD_COUNT; r++) begin
      match_o[r] = match_i[r] && (pos_i < LEN_W'(9)) &&
                   (ctl_pkg::kw_char(r, int'(pos_i[3:0])) == ch_i);
    end
  end

  always_comb begin
    is_kw_o = 1'b0;
    if (pos_i != '0 && pos_i < LEN_W'(9)) begin
      for (int r = 0; r < KEYWORD_COUNT; r++) begin
        if (match_i[r] && ctl_pkg::kw_char(r, int'(pos_i[3:0])) == 8'd0) is_kw_o = 1'b1;
      end
    end
  end
endmodule
`default_nettype wire

// File: src/ctl_step.sv
// Scanner state machine: one character step and flush, up to two tokens.
`default_nettype none
module ctl_step #(
  parameter int MAX_TOKEN_LEN = ctl_pkg::MAX_TOKEN_LEN_DEF,
  parameter int KEYWORD_COUNT = ctl_pkg::KEYWORD_COUNT_DEF,
  parameter int LEN_W = $clog2(MAX_TOKEN_LEN + 1)
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     step_i,
  input  wire logic [7:0]               ch_i,
  input  wire logic                     eot_i,
  output ctl_pkg::tok_pair_t            toks_o
);
  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_TOKEN_LEN);

  ctl_pkg::scan_st_t state_r, state_nxt, st_adv;
  logic [LEN_W-1:0] len_r, len_nxt, len_adv, grown;
  logic [KEYWORD_COUNT-1:0] kw_r, kw_nxt, kw_adv, kw_upd, kw_first;
  logic quote_r, quote_nxt, quote_adv;
  logic word_kw, dummy_kw;
  ctl_pkg::tok_t ta, tb, tf;

  ctl_kw_match #(.KEYWORD_COUNT(KEYWORD_COUNT), .LEN_W(LEN_W)) u_kw (
    .match_i(kw_r), .pos_i(len_r), .ch_i(ch_i), .match_o(kw_upd), .is_kw_o(word_kw)
  );
  ctl_kw_match #(.KEYWORD_COUNT(KEYWORD_COUNT), .LEN_W(LEN_W)) u_kw0 (
    .match_i({KEYWORD_COUNT{1'b1}}), .pos_i('0), .ch_i(ch_i), .match_o(kw_first),
    .is_kw_o(dummy_kw)
  );

  function automatic logic [7:0] sat8(input logic [LEN_W-1:0] v);
    logic [31:0] w;
    w = 32'(v);
    return (w > 32'd255) ? 8'd255 : w[7:0];
  endfunction

  assign grown = (len_r < LEN_MAX) ? len_r + LEN_W'(1) : len_r;

  // Next state
  always_comb begin
    logic restart, bad, done;
    logic [5:0] rcls;
    restart = 1'b0; bad = 1'b0; done = 1'b0; rcls = ctl_pkg::K_WORD;
    st_adv = state_r; len_adv = len_r; kw_adv = kw_r; quote_adv = quote_r;
    ta = '0; tb = '0;
    unique case (state_r)
      ctl_pkg::ST_IDLE: restart = 1'b1;
      ctl_pkg::ST_WORD:
        if (ctl_pkg::is_letter(ch_i)) begin kw_adv = kw_upd; len_adv = grown; end
        else begin restart = 1'b1; rcls = word_kw ? ctl_pkg::K_KEYWORD : ctl_pkg::K_WORD; end
      ctl_pkg::ST_ZERO:
        if (ch_i == "x" || ch_i == "X") begin st_adv = ctl_pkg::ST_ZEROX; len_adv = grown; end
        else if (ctl_pkg::is_oct(ch_i)) begin st_adv = ctl_pkg::ST_OCT; len_adv = grown; end
        else if (ctl_pkg::is_digit(ch_i)) begin st_adv = ctl_pkg::ST_INT; len_adv = grown; end
        else if (ch_i == ".") begin st_adv = ctl_pkg::ST_FRAC0; len_adv = grown; end
        else begin restart = 1'b1; rcls = ctl_pkg::K_ZERO; end
      ctl_pkg::ST_ZEROX:
        if (ctl_pkg::is_hex(ch_i)) begin st_adv = ctl_pkg::ST_HEX; len_adv = grown; end
        else bad = 1'b1;
      ctl_pkg::ST_HEX:
        if (ctl_pkg::is_hex(ch_i)) len_adv = grown;
        else begin restart = 1'b1; rcls = ctl_pkg::K_HEX; end
      ctl_pkg::ST_OCT:
        if (ctl_pkg::is_oct(ch_i)) len_adv = grown;
        else begin restart = 1'b1; rcls = ctl_pkg::K_OCT; end
      ctl_pkg::ST_INT:
        if (ctl_pkg::is_digit(ch_i)) len_adv = grown;
        else if (ch_i == ".") begin st_adv = ctl_pkg::ST_FRAC0; len_adv = grown; end
        else begin restart = 1'b1; rcls = ctl_pkg::K_INT; end
      ctl_pkg::ST_FRAC0:
        if (ctl_pkg::is_digit(ch_i)) begin st_adv = ctl_pkg::ST_FRAC; len_adv = grown; end
        else bad = 1'b1;
      ctl_pkg::ST_FRAC:
        if (ctl_pkg::is_digit(ch_i)) len_adv = grown;
        else if (ch_i == "e" || ch_i == "E") begin
          st_adv = ctl_pkg::ST_EXP0; len_adv = grown;
        end else begin restart = 1'b1; rcls = ctl_pkg::K_FLOAT; end
      ctl_pkg::ST_EXP0:
        if (ctl_pkg::is_digit(ch_i)) begin st_adv = ctl_pkg::ST_EXPD; len_adv = grown; end
        else if (ch_i == "+" || ch_i == "-") begin
          st_adv = ctl_pkg::ST_EXPS; len_adv = grown;
        end else bad = 1'b1;
      ctl_pkg::ST_EXPS:
        if (ctl_pkg::is_digit(ch_i)) begin st_adv = ctl_pkg::ST_EXPD; len_adv = grown; end
        else bad = 1'b1;
      ctl_pkg::ST_EXPD:
        if (ctl_pkg::is_digit(ch_i)) len_adv = grown;
        else begin restart = 1'b1; rcls = ctl_pkg::K_FLOAT; end
      ctl_pkg::ST_SLASH:
        if (ch_i == "*") begin st_adv = ctl_pkg::ST_COMMENT; len_adv = '0; end
        else if (ch_i == "=") begin
          ta = '{1'b1, ctl_pkg::K_SLASHEQ, 8'd2}; done = 1'b1;
        end else begin restart = 1'b1; rcls = ctl_pkg::K_SLASH; end
      ctl_pkg::ST_COMMENT:
        if (ch_i == "*") st_adv = ctl_pkg::ST_CSTAR;
      ctl_pkg::ST_CSTAR:
        if (ch_i == "/") done = 1'b1;
        else if (ch_i != "*") st_adv = ctl_pkg::ST_COMMENT;
      ctl_pkg::ST_STRING: begin
        len_adv = grown;
        if (ch_i == (quote_r ? 8'h22 : 8'h27)) begin
          ta = '{1'b1, ctl_pkg::K_STRING, sat8(grown)}; done = 1'b1;
        end
      end
      ctl_pkg::ST_OP_PLUS:
        if (ch_i == "=") begin ta = '{1'b1, ctl_pkg::K_PLUSEQ, 8'd2}; done = 1'b1; end
        else begin restart = 1'b1; rcls = ctl_pkg::K_PLUS; end
      ctl_pkg::ST_OP_MINUS:
        if (ch_i == ">") begin ta = '{1'b1, ctl_pkg::K_ARROW, 8'd2}; done = 1'b1; end
        else if (ch_i == "=") begin ta = '{1'b1, ctl_pkg::K_MINUSEQ, 8'd2}; done = 1'b1; end
        else begin restart = 1'b1; rcls = ctl_pkg::K_MINUS; end
      ctl_pkg::ST_OP_STAR:
        if (ch_i == "=") begin ta = '{1'b1, ctl_pkg::K_STAREQ, 8'd2}; done = 1'b1; end
        else begin restart = 1'b1; rcls = ctl_pkg::K_STAR; end
      ctl_pkg::ST_OP_PCT:
        if (ch_i == "=") begin ta = '{1'b1, ctl_pkg::K_PCTEQ, 8'd2}; done = 1'b1; end
        else begin restart = 1'b1; rcls = ctl_pkg::K_PCT; end
      ctl_pkg::ST_OP_AMP:
        if (ch_i == "=") begin ta = '{1'b1, ctl_pkg::K_AMPEQ, 8'd2}; done = 1'b1; end
        else if (ch_i == "&") begin ta = '{1'b1, ctl_pkg::K_ANDAND, 8'd2}; done = 1'b1; end
        else begin restart = 1'b1; rcls = ctl_pkg::K_AMP; end
      ctl_pkg::ST_OP_CARET:
        if (ch_i == "=") begin ta = '{1'b1, ctl_pkg::K_CARETEQ, 8'd2}; done = 1'b1; end
        else begin restart = 1'b1; rcls = ctl_pkg::K_CARET; end
      ctl_pkg::ST_OP_BAR:
        if (ch_i == "|") begin ta = '{1'b1, ctl_pkg::K_OROR, 8'd2}; done = 1'b1; end
        else begin restart = 1'b1; rcls = ctl_pkg::K_BAR; end
      ctl_pkg::ST_OP_LT:
        if (ch_i == "=") begin ta = '{1'b1, ctl_pkg::K_LE, 8'd2}; done = 1'b1; end
        else begin restart = 1'b1; rcls = ctl_pkg::K_LT; end
      ctl_pkg::ST_OP_GT:
        if (ch_i == "=") begin ta = '{1'b1, ctl_pkg::K_GE, 8'd2}; done = 1'b1; end
        else begin restart = 1'b1; rcls = ctl_pkg::K_GT; end
      ctl_pkg::ST_OP_EQ:
        if (ch_i == "=") begin ta = '{1'b1, ctl_pkg::K_EQEQ, 8'd2}; done = 1'b1; end
        else begin restart = 1'b1; rcls = ctl_pkg::K_ASSIGN; end
      default: restart = 1'b1;
    endcase

    if (bad) begin
      ta = '{1'b1, ctl_pkg::K_MAL, sat8(grown)}; done = 1'b1;
    end
    if (done) begin
      st_adv = ctl_pkg::ST_IDLE; len_adv = '0; kw_adv = '1; quote_adv = 1'b0;
    end
    if (restart) begin
      // pending token first (none from idle), then the new token start
      if (state_r != ctl_pkg::ST_IDLE) ta = '{1'b1, rcls, sat8(len_r)};
      st_adv = ctl_pkg::ST_IDLE; len_adv = LEN_W'(1); kw_adv = '1; quote_adv = 1'b0;
      tb = '0;
      if (ctl_pkg::is_letter(ch_i)) begin st_adv = ctl_pkg::ST_WORD; kw_adv = kw_first; end
      else if (ch_i == "0") st_adv = ctl_pkg::ST_ZERO;
      else if (ctl_pkg::is_digit(ch_i)) st_adv = ctl_pkg::ST_INT;
      else if (ch_i == 8'h27 || ch_i == 8'h22) begin
        st_adv = ctl_pkg::ST_STRING; quote_adv = (ch_i == 8'h22);
      end else begin
        case (ch_i)
          "/": st_adv = ctl_pkg::ST_SLASH;
          "+": st_adv = ctl_pkg::ST_OP_PLUS;
          "-": st_adv = ctl_pkg::ST_OP_MINUS;
          "*": st_adv = ctl_pkg::ST_OP_STAR;
          "%": st_adv = ctl_pkg::ST_OP_PCT;
          "&": st_adv = ctl_pkg::ST_OP_AMP;
          "^": st_adv = ctl_pkg::ST_OP_CARET;
          "|": st_adv = ctl_pkg::ST_OP_BAR;
          "<": st_adv = ctl_pkg::ST_OP_LT;
          ">": st_adv = ctl_pkg::ST_OP_GT;
          "=": st_adv = ctl_pkg::ST_OP_EQ;
          "[": tb = '{1'b1, ctl_pkg::K_LBRK, 8'd1};
          "]": tb = '{1'b1, ctl_pkg::K_RBRK, 8'd1};
          "(": tb = '{1'b1, ctl_pkg::K_LPAR, 8'd1};
          ")": tb = '{1'b1, ctl_pkg::K_RPAR, 8'd1};
          ".": tb = '{1'b1, ctl_pkg::K_DOT, 8'd1};
          "?": tb = '{1'b1, ctl_pkg::K_QUEST, 8'd1};
          "~": tb = '{1'b1, ctl_pkg::K_TILDE, 8'd1};
          ",": tb = '{1'b1, ctl_pkg::K_COMMA, 8'd1};
          default: ;
        endcase
        if (st_adv == ctl_pkg::ST_IDLE) len_adv = '0;
      end
    end
  end

  // Flush of the post-step state at end of text
  always_comb begin
    tf = '0;
    tf.len = sat8(len_adv);
    tf.vld = 1'b1;
    unique case (st_adv)
      ctl_pkg::ST_WORD: begin
        tf.cls = ctl_pkg::K_WORD;
        if (len_adv != '0 && len_adv < LEN_W'(9)) begin
          for (int r = 0; r < KEYWORD_COUNT; r++) begin
            if (kw_adv[r] && ctl_pkg::kw_char(r, int'(len_adv[3:0])) == 8'd0)
              tf.cls = ctl_pkg::K_KEYWORD;
          end
        end
      end
      ctl_pkg::ST_ZERO: tf.cls = ctl_pkg::K_ZERO;
      ctl_pkg::ST_HEX: tf.cls = ctl_pkg::K_HEX;
      ctl_pkg::ST_OCT: tf.cls = ctl_pkg::K_OCT;
      ctl_pkg::ST_INT: tf.cls = ctl_pkg::K_INT;
      ctl_pkg::ST_FRAC, ctl_pkg::ST_EXPD: tf.cls = ctl_pkg::K_FLOAT;
      ctl_pkg::ST_ZEROX, ctl_pkg::ST_FRAC0, ctl_pkg::ST_EXP0, ctl_pkg::ST_EXPS:
        tf.cls = ctl_pkg::K_MAL;
      ctl_pkg::ST_SLASH: tf.cls = ctl_pkg::K_SLASH;
      ctl_pkg::ST_STRING: tf.cls = quote_adv ? ctl_pkg::K_USTR2 : ctl_pkg::K_USTR1;
      ctl_pkg::ST_OP_PLUS: tf.cls = ctl_pkg::K_PLUS;
      ctl_pkg::ST_OP_MINUS: tf.cls = ctl_pkg::K_MINUS;
      ctl_pkg::ST_OP_STAR: tf.cls = ctl_pkg::K_STAR;
      ctl_pkg::ST_OP_PCT: tf.cls = ctl_pkg::K_PCT;
      ctl_pkg::ST_OP_AMP: tf.cls = ctl_pkg::K_AMP;
      ctl_pkg::ST_OP_CARET: tf.cls = ctl_pkg::K_CARET;
      ctl_pkg::ST_OP_BAR: tf.cls = ctl_pkg::K_BAR;
      ctl_pkg::ST_OP_LT: tf.cls = ctl_pkg::K_LT;
      ctl_pkg::ST_OP_GT: tf.cls = ctl_pkg::K_GT;
      ctl_pkg::ST_OP_EQ: tf.cls = ctl_pkg::K_ASSIGN;
      default: tf.vld = 1'b0;
    endcase
  end

  // Outputs: pack up to two tokens in order, first slot filled first
  always_comb begin
    ctl_pkg::tok_t l0, l1, l2;
    l0 = ta; l1 = tb; l2 = eot_i ? tf : '0;
    toks_o = '0;
    if (l0.vld) begin
      toks_o.t0 = l0;
      toks_o.t1 = l1.vld ? l1 : l2;
    end else if (l1.vld) begin
      toks_o.t0 = l1; toks_o.t1 = l2;
    end else begin
      toks_o.t0 = l2;
    end
  end

  always_comb begin
    state_nxt = st_adv; len_nxt = len_adv; kw_nxt = kw_adv; quote_nxt = quote_adv;
    if (eot_i) begin
      state_nxt = ctl_pkg::ST_IDLE; len_nxt = '0; kw_nxt = '1; quote_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ctl_pkg::ST_IDLE;
      len_r <= '0;
      kw_r <= '1;
      quote_r <= 1'b0;
    end else if (step_i) begin
      state_r <= state_nxt;
      len_r <= len_nxt;
      kw_r <= kw_nxt;
      quote_r <= quote_nxt;
    end
  end
endmodule
`default_nettype wire
